/* design/vat_pkg.sv */
// Shared constants and types for the vertex affine transform block.
package vat_pkg;

    // Signed Q16.16 coordinate.
    typedef logic signed [31:0] coord_t;

    // Transform selection held in the mode register.
    localparam logic [1:0] MODE_ROTATE    = 2'd0;
    localparam logic [1:0] MODE_TRANSLATE = 2'd1;
    localparam logic [1:0] MODE_SCALE     = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_PIVOT_X = 3'd1;
    localparam logic [2:0] REG_PIVOT_Y = 3'd2;
    localparam logic [2:0] REG_ANGLE   = 3'd3;
    localparam logic [2:0] REG_DELTA_X = 3'd4;
    localparam logic [2:0] REG_DELTA_Y = 3'd5;
    localparam logic [2:0] REG_SCALE   = 3'd6;

    // Guard bits carried below the coordinate LSB through the rotator.
    localparam int GUARD = 4;

    // Number of arctangent entries available.
    localparam int TABLE_LEN = 24;

    // Rotator gain K = 0.6072529350 in Q0.32.
    localparam logic [63:0] GAIN_Q32 = 64'd2608131496;

    // atan(2^-i) in 32-bit binary angle units, rounded to nearest.
    localparam logic signed [31:0] ATAN_TABLE [TABLE_LEN] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

endpackage

/* design/vertex_affine_transform.sv */
// Vertex transform pipeline: rotate about a pivot, translate or scale.
//
// One vertex is accepted every clock cycle while the skid register is
// empty. Each vertex passes through the registered stages in order: the
// offset from the pivot and exact quarter turn, the CORDIC micro-rotation
// stages, the split gain or scale multiply, the rounding, and the pivot
// add and saturation. The mode,
// pivot, angle, offset and scale registers must only be written while no
// vertex is in flight. A two-entry output (result register plus skid
// register) lets the pipeline take one more vertex while a result waits;
// s_tready drops only once the skid register is full.
module vertex_affine_transform #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Input vertex stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] vertex_x, [63:32] vertex_y
    input  logic        s_tlast,   // last_vertex
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] result_x, [63:32] result_y
    output logic        m_tlast    // result_last
);

    // Datapath widths.
    localparam int W   = 34 + vat_pkg::GUARD + 3;
    localparam int LO  = W / 2;
    localparam int HW  = W - LO;
    localparam int OPW = 24;
    localparam int PW  = W + OPW + 1;

    // Stage indexes.
    localparam int NS = CORDIC_STAGES + 4;
    localparam int RS = CORDIC_STAGES + 2;
    localparam int OS = CORDIC_STAGES + 3;

    // Gain correction and rounding constants.
    localparam logic [63:0] GAIN_WIDE =
        (vat_pkg::GAIN_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [OPW-1:0] GAIN = GAIN_WIDE[OPW-1:0];
    localparam int ROT_SHIFT   = FRAC_BITS + vat_pkg::GUARD;
    localparam int SCALE_SHIFT = 16;
    localparam logic signed [PW-1:0] ROT_HALF =
        {{(PW-1){1'b0}}, 1'b1} << (ROT_SHIFT - 1);
    localparam logic signed [PW-1:0] SCALE_HALF =
        {{(PW-1){1'b0}}, 1'b1} << (SCALE_SHIFT - 1);

    // Configuration registers.
    logic [1:0]      mode_reg;
    vat_pkg::coord_t pivot_x_reg;
    vat_pkg::coord_t pivot_y_reg;
    logic [15:0]     angle_reg;
    vat_pkg::coord_t delta_x_reg;
    vat_pkg::coord_t delta_y_reg;
    logic [23:0]     scale_reg;

    // Pipeline control.
    logic            en;
    logic [NS-1:0]   vld_reg;
    logic [NS-1:0]   lst_reg;
    logic            skid_vld_reg;
    logic            skid_vld_next;

    // Pipeline payload.
    logic signed [W-1:0]         cx_reg [0:CORDIC_STAGES];
    logic signed [W-1:0]         cy_reg [0:CORDIC_STAGES];
    logic signed [31:0]          cz_reg [0:CORDIC_STAGES];
    logic signed [HW+OPW:0]      phx_reg;
    logic signed [HW+OPW:0]      phy_reg;
    logic signed [LO+OPW+1:0]    plx_reg;
    logic signed [LO+OPW+1:0]    ply_reg;
    logic signed [W-1:0]         rx_reg;
    logic signed [W-1:0]         ry_reg;
    vat_pkg::coord_t             ox_reg;
    vat_pkg::coord_t             oy_reg;
    vat_pkg::coord_t             skid_x_reg;
    vat_pkg::coord_t             skid_y_reg;
    logic                        skid_last_reg;

    // Saturate a wide signed value to the coordinate range.
    function automatic vat_pkg::coord_t sat_coord(input logic signed [W:0] v);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[W:31];
        hi_zeros = ~|v[W:31];
        if (hi_ones || hi_zeros)
        begin
            return v[31:0];
        end
        else if (v[W])
        begin
            return 32'sh8000_0000;
        end
        else
        begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= vat_pkg::MODE_ROTATE;
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
            angle_reg   <= '0;
            delta_x_reg <= '0;
            delta_y_reg <= '0;
            scale_reg   <= 24'd65536;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                vat_pkg::REG_MODE:    mode_reg    <= cfg_data[1:0];
                vat_pkg::REG_PIVOT_X: pivot_x_reg <= cfg_data;
                vat_pkg::REG_PIVOT_Y: pivot_y_reg <= cfg_data;
                vat_pkg::REG_ANGLE:   angle_reg   <= cfg_data[15:0];
                vat_pkg::REG_DELTA_X: delta_x_reg <= cfg_data;
                vat_pkg::REG_DELTA_Y: delta_y_reg <= cfg_data;
                vat_pkg::REG_SCALE:   scale_reg   <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances while the skid register is empty.
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lst_reg <= {lst_reg[NS-2:0], s_tlast};
        end
    end

    // The skid register catches a result that is not taken while the pipe moves.
    always_comb
    begin
        if (skid_vld_reg)
        begin
            skid_vld_next = !m_tready;
        end
        else
        begin
            skid_vld_next = vld_reg[OS] && !m_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_vld_reg)
        begin
            skid_x_reg    <= ox_reg;
            skid_y_reg    <= oy_reg;
            skid_last_reg <= lst_reg[OS];
        end
    end

    assign m_tvalid = skid_vld_reg || vld_reg[OS];
    assign m_tdata  = skid_vld_reg ? {skid_y_reg, skid_x_reg} : {oy_reg, ox_reg};
    assign m_tlast  = skid_vld_reg ? skid_last_reg : lst_reg[OS];

    // Stage 0: offset from the pivot, exact quarter turn and residual angle; translation adds the delta here.
    vat_pkg::coord_t      vx;
    vat_pkg::coord_t      vy;
    logic signed [32:0]   dx;
    logic signed [32:0]   dy;
    logic signed [33:0]   dxe;
    logic signed [33:0]   dye;
    logic signed [33:0]   qx;
    logic signed [33:0]   qy;
    logic signed [32:0]   tx;
    logic signed [32:0]   ty;
    logic [15:0]          ang_sum;
    logic signed [31:0]   z_init;
    logic signed [W-1:0]  x_init;
    logic signed [W-1:0]  y_init;

    assign vx      = s_tdata[31:0];
    assign vy      = s_tdata[63:32];
    assign dx      = {vx[31], vx} - {pivot_x_reg[31], pivot_x_reg};
    assign dy      = {vy[31], vy} - {pivot_y_reg[31], pivot_y_reg};
    assign dxe     = {dx[32], dx};
    assign dye     = {dy[32], dy};
    assign tx      = {vx[31], vx} + {delta_x_reg[31], delta_x_reg};
    assign ty      = {vy[31], vy} + {delta_y_reg[31], delta_y_reg};
    assign ang_sum = angle_reg + 16'h2000;
    assign z_init  = {{3{~ang_sum[13]}}, ang_sum[12:0], 16'b0};

    always_comb
    begin
        case (ang_sum[15:14])
            2'd1:
            begin
                qx = -dye;
                qy = dxe;
            end
            2'd2:
            begin
                qx = -dxe;
                qy = -dye;
            end
            2'd3:
            begin
                qx = dye;
                qy = -dxe;
            end
            default:
            begin
                qx = dxe;
                qy = dye;
            end
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            vat_pkg::MODE_ROTATE:
            begin
                x_init = {{(W-34-vat_pkg::GUARD){qx[33]}}, qx, {vat_pkg::GUARD{1'b0}}};
                y_init = {{(W-34-vat_pkg::GUARD){qy[33]}}, qy, {vat_pkg::GUARD{1'b0}}};
            end
            vat_pkg::MODE_TRANSLATE:
            begin
                x_init = {{(W-33){tx[32]}}, tx};
                y_init = {{(W-33){ty[32]}}, ty};
            end
            default:
            begin
                x_init = {{(W-32){vx[31]}}, vx};
                y_init = {{(W-32){vy[31]}}, vy};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0] <= x_init;
            cy_reg[0] <= y_init;
            cz_reg[0] <= z_init;
        end
    end

    // Stages 1 to CORDIC_STAGES: one micro-rotation each; other modes pass.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;

        assign xs = cx_reg[i] >>> i;
        assign ys = cy_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (mode_reg != vat_pkg::MODE_ROTATE)
                begin
                    cx_reg[i+1] <= cx_reg[i];
                    cy_reg[i+1] <= cy_reg[i];
                    cz_reg[i+1] <= cz_reg[i];
                end
                else if (!cz_reg[i][31])
                begin
                    cx_reg[i+1] <= cx_reg[i] - ys;
                    cy_reg[i+1] <= cy_reg[i] + xs;
                    cz_reg[i+1] <= cz_reg[i] - vat_pkg::ATAN_TABLE[i];
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + ys;
                    cy_reg[i+1] <= cy_reg[i] - xs;
                    cz_reg[i+1] <= cz_reg[i] + vat_pkg::ATAN_TABLE[i];
                end
            end
        end
    end

    // Multiply stage: gain, scale or unity, split into high and low halves.
    logic [OPW-1:0]      mul_op;
    logic signed [W-1:0] mx;
    logic signed [W-1:0] my;

    assign mx = cx_reg[CORDIC_STAGES];
    assign my = cy_reg[CORDIC_STAGES];

    always_comb
    begin
        case (mode_reg)
            vat_pkg::MODE_ROTATE: mul_op = GAIN;
            vat_pkg::MODE_SCALE:  mul_op = scale_reg;
            default:              mul_op = {{(OPW-1){1'b0}}, 1'b1};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phx_reg <= $signed(mx[W-1:LO]) * $signed({1'b0, mul_op});
            phy_reg <= $signed(my[W-1:LO]) * $signed({1'b0, mul_op});
            plx_reg <= $signed({1'b0, mx[LO-1:0]}) * $signed({1'b0, mul_op});
            ply_reg <= $signed({1'b0, my[LO-1:0]}) * $signed({1'b0, mul_op});
        end
    end

    // Rounding stage: join the partial products, add half and shift.
    logic signed [PW-1:0] rnd_half;
    logic signed [PW-1:0] sum_x;
    logic signed [PW-1:0] sum_y;
    logic signed [PW-1:0] shx;
    logic signed [PW-1:0] shy;

    always_comb
    begin
        case (mode_reg)
            vat_pkg::MODE_ROTATE: rnd_half = ROT_HALF;
            vat_pkg::MODE_SCALE:  rnd_half = SCALE_HALF;
            default:              rnd_half = '0;
        endcase
    end

    assign sum_x = {phx_reg, {LO{1'b0}}}
                 + {{(HW-1){plx_reg[LO+OPW+1]}}, plx_reg} + rnd_half;
    assign sum_y = {phy_reg, {LO{1'b0}}}
                 + {{(HW-1){ply_reg[LO+OPW+1]}}, ply_reg} + rnd_half;

    always_comb
    begin
        case (mode_reg)
            vat_pkg::MODE_ROTATE:
            begin
                shx = sum_x >>> ROT_SHIFT;
                shy = sum_y >>> ROT_SHIFT;
            end
            vat_pkg::MODE_SCALE:
            begin
                shx = sum_x >>> SCALE_SHIFT;
                shy = sum_y >>> SCALE_SHIFT;
            end
            default:
            begin
                shx = sum_x;
                shy = sum_y;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= shx[W-1:0];
            ry_reg <= shy[W-1:0];
        end
    end

    // Output stage: add the pivot back for rotation and saturate.
    logic signed [W:0] fx;
    logic signed [W:0] fy;

    always_comb
    begin
        if (mode_reg == vat_pkg::MODE_ROTATE)
        begin
            fx = {rx_reg[W-1], rx_reg} + {{(W-31){pivot_x_reg[31]}}, pivot_x_reg};
            fy = {ry_reg[W-1], ry_reg} + {{(W-31){pivot_y_reg[31]}}, pivot_y_reg};
        end
        else
        begin
            fx = {rx_reg[W-1], rx_reg};
            fy = {ry_reg[W-1], ry_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg <= sat_coord(fx);
            oy_reg <= sat_coord(fy);
        end
    end

`ifndef ASSERT_OFF
    // A result left waiting while the pipe moves must land in the skid register.
    a_skid_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[OS] && !skid_vld_reg && !m_tready) |=> skid_vld_reg)
        else $error("waiting result not caught by skid register");

    // A taken skid entry frees the register.
    a_skid_release: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_vld_reg && m_tready) |=> !skid_vld_reg)
        else $error("skid register not released after transfer");

    // While the skid register is full no stage may move.
    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |=> $stable(vld_reg))
        else $error("pipeline moved while skid register full");

    // A new result comes only from the rounding stage.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(vld_reg[OS]) |-> $past(vld_reg[RS]))
        else $error("result valid without rounding stage item");
`endif

endmodule
